>>> src/gts_pkg.sv
// Shared types, codes and saturation helpers for the grid track sizer.
// Used by gts_ctrl, gts_dp and grid_track_sizer_core.
// Depends on nothing else.
package gts_pkg;

	// Default track storage depth and fixed point format.
	localparam int GTS_MAX_TRACKS = 32;
	localparam int FRAC_BITS      = 8;
	localparam int LEN_W          = 24;
	localparam int EXT_W          = 23;

	// Item function codes.
	localparam logic [1:0] FUNC_LOAD    = 2'd0;
	localparam logic [1:0] FUNC_NEED    = 2'd1;
	localparam logic [1:0] FUNC_RESOLVE = 2'd2;
	localparam logic [1:0] FUNC_PLACE   = 2'd3;

	// Track mode codes.
	localparam logic [1:0] MODE_AUTO  = 2'd0;
	localparam logic [1:0] MODE_PIXEL = 2'd1;
	localparam logic [1:0] MODE_STAR  = 2'd2;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_COUNT  = 2'd0;
	localparam logic [1:0] REG_GAP    = 2'd1;
	localparam logic [1:0] REG_AVAIL  = 2'd2;
	localparam logic [1:0] REG_ORIGIN = 2'd3;

	// A star weight of zero or less counts as one.
	localparam logic [EXT_W-1:0] W_ONE = EXT_W'(1) << FRAC_BITS;

	// Datapath phase codes issued by the controller.
	localparam logic [3:0] P_NONE      = 4'd0;
	localparam logic [3:0] P_NEED_SUM  = 4'd1;
	localparam logic [3:0] P_NEED_UPD  = 4'd2;
	localparam logic [3:0] P_RES_SUM   = 4'd3;
	localparam logic [3:0] P_RES_REM   = 4'd4;
	localparam logic [3:0] P_RES_MUL   = 4'd5;
	localparam logic [3:0] P_RES_WR    = 4'd6;
	localparam logic [3:0] P_SKIP      = 4'd7;
	localparam logic [3:0] P_EMIT      = 4'd8;
	localparam logic [3:0] P_PLACE_SUM = 4'd9;
	localparam logic [3:0] P_PLACE_OUT = 4'd10;

	typedef struct packed {
		logic [1:0]        func;
		logic [15:0]       track_index;
		logic [15:0]       span;
		logic [1:0]        mode;
		logic signed [23:0] value;
		logic signed [23:0] need;
		logic signed [23:0] margin_before;
		logic signed [23:0] margin_after;
	} item_t;

	typedef struct packed {
		logic [4:0]         result_index;
		logic signed [23:0] position;
		logic [22:0]        extent;
		logic               last;
	} result_t;

	typedef struct packed {
		logic       take;
		logic       rewind;
		logic       div_go;
		logic [3:0] phase;
	} cmd_t;

	typedef struct packed {
		logic last_step;
		logic autos_nz;
		logic excess_pos;
		logic tw_nz;
		logic is_star;
		logic div_busy;
		logic out_free;
	} stat_t;

	// Clamp a wide signed value to an extent.
	function automatic logic [EXT_W-1:0] sat_ext(input logic signed [47:0] v);
		logic [EXT_W-1:0] r;
		if (v < 48'sd0) begin
			r = '0;
		end else if (v > 48'sd8388607) begin
			r = '1;
		end else begin
			r = v[EXT_W-1:0];
		end
		return r;
	endfunction

	// Clamp a wide signed value to a 24-bit signed position.
	function automatic logic signed [LEN_W-1:0] sat_pos(input logic signed [47:0] v);
		logic signed [LEN_W-1:0] r;
		if (v < -48'sd8388608) begin
			r = 24'sh800000;
		end else if (v > 48'sd8388607) begin
			r = 24'sh7FFFFF;
		end else begin
			r = v[LEN_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> src/gts_div.sv
// Restoring divider, one quotient bit per cycle, for the grid track sizer.
// Uses nothing from gts_pkg.
module gts_div #(
	parameter int DW = 46,
	parameter int VW = 28
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quotient
);
	localparam int KW = $clog2(DW + 1);

	logic [VW:0]   rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] dvs_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q;
	logic [VW:0]   shifted;
	logic          fits;

	// Shift in the next dividend bit and try a subtraction.
	assign shifted = {rem_q[VW-1:0], quo_q[DW-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (go) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvs_q  <= divisor;
			cnt_q  <= KW'(DW);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			rem_q  <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
			quo_q  <= {quo_q[DW-2:0], fits};
			cnt_q  <= cnt_q - KW'(1);
			busy_q <= cnt_q != KW'(1);
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule

>>> src/gts_ctrl.sv
// Sequencing state machine of the grid track sizer.
// Depends on gts_pkg for the command, status and phase codes.
module gts_ctrl
	import gts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic [1:0] func,
	output logic       item_stall,
	input  stat_t      stat,
	output cmd_t       cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_NSUM = 4'd1;
	localparam logic [3:0] S_NCHK = 4'd2;
	localparam logic [3:0] S_NDIV = 4'd3;
	localparam logic [3:0] S_NUPD = 4'd4;
	localparam logic [3:0] S_RSUM = 4'd5;
	localparam logic [3:0] S_RREM = 4'd6;
	localparam logic [3:0] S_RCHK = 4'd7;
	localparam logic [3:0] S_RGO  = 4'd8;
	localparam logic [3:0] S_RDIV = 4'd9;
	localparam logic [3:0] S_REW  = 4'd10;
	localparam logic [3:0] S_EMIT = 4'd11;
	localparam logic [3:0] S_PSUM = 4'd12;
	localparam logic [3:0] S_POUT = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign item_stall = state_q != S_IDLE;

	// Next state and command for the datapath.
	always_comb begin
		state_d    = state_q;
		cmd.take   = 1'b0;
		cmd.rewind = 1'b0;
		cmd.div_go = 1'b0;
		cmd.phase  = P_NONE;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.take = 1'b1;
					case (func)
						FUNC_NEED:    state_d = S_NSUM;
						FUNC_RESOLVE: state_d = S_RSUM;
						FUNC_PLACE:   state_d = S_PSUM;
						default:      state_d = S_IDLE;
					endcase
				end
			end
			S_NSUM: begin
				cmd.phase = P_NEED_SUM;
				if (stat.last_step) state_d = S_NCHK;
			end
			S_NCHK: begin
				if (stat.autos_nz && stat.excess_pos) begin
					cmd.div_go = 1'b1;
					cmd.rewind = 1'b1;
					state_d    = S_NDIV;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_NDIV: begin
				if (!stat.div_busy) state_d = S_NUPD;
			end
			S_NUPD: begin
				cmd.phase = P_NEED_UPD;
				if (stat.last_step) state_d = S_IDLE;
			end
			S_RSUM: begin
				cmd.phase = P_RES_SUM;
				if (stat.last_step) state_d = S_RREM;
			end
			S_RREM: begin
				cmd.phase  = P_RES_REM;
				cmd.rewind = 1'b1;
				state_d    = stat.tw_nz ? S_RCHK : S_EMIT;
			end
			S_RCHK: begin
				if (stat.is_star) begin
					cmd.phase = P_RES_MUL;
					state_d   = S_RGO;
				end else begin
					cmd.phase = P_SKIP;
					if (stat.last_step) state_d = S_REW;
				end
			end
			S_RGO: begin
				cmd.div_go = 1'b1;
				state_d    = S_RDIV;
			end
			S_RDIV: begin
				if (!stat.div_busy) begin
					cmd.phase = P_RES_WR;
					state_d   = stat.last_step ? S_REW : S_RCHK;
				end
			end
			S_REW: begin
				cmd.rewind = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.phase = P_EMIT;
					if (stat.last_step) state_d = S_IDLE;
				end
			end
			S_PSUM: begin
				cmd.phase = P_PLACE_SUM;
				if (stat.last_step) state_d = S_POUT;
			end
			S_POUT: begin
				if (stat.out_free) begin
					cmd.phase = P_PLACE_OUT;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The divider is never restarted while it is still working.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.div_go |-> !stat.div_busy)
		else $error("divider started while busy");

	// A result word is only loaded when the output register can take it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.phase == P_EMIT || cmd.phase == P_PLACE_OUT) |-> stat.out_free)
		else $error("output register overwritten");

	// A load item finishes in the cycle it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && func == FUNC_LOAD) |=> state_q == S_IDLE)
		else $error("load item did not finish at once");

	// The input side is only taken while idle.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.take |-> !item_stall)
		else $error("item taken while busy");
endmodule

>>> src/gts_dp.sv
// Datapath of the grid track sizer: configuration, track storage, walk
// accumulators, shared divider and output register. Depends on gts_pkg and gts_div.
module gts_dp
	import gts_pkg::*;
#(
	parameter int MAX_TRACKS = GTS_MAX_TRACKS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  item_t       item,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output result_t     result,
	output logic        result_valid,
	input  logic        result_stall
);
	localparam int IW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int CW  = $clog2(MAX_TRACKS + 1);
	localparam int UW  = EXT_W + 1 + CW;
	localparam int SW  = UW + 2;
	localparam int TWW = EXT_W + CW;
	localparam int PW  = 2 * EXT_W;

	// Configuration registers.
	logic [5:0]              count_q;
	logic [EXT_W-1:0]        gap_q;
	logic [EXT_W-1:0]        avail_q;
	logic signed [LEN_W-1:0] origin_q;

	// Track storage.
	logic [1:0]              mode_q [MAX_TRACKS];
	logic signed [LEN_W-1:0] val_q  [MAX_TRACKS];
	logic [EXT_W-1:0]        size_q [MAX_TRACKS];
	logic signed [LEN_W-1:0] pos_q  [MAX_TRACKS];

	// Walk state and accumulators.
	logic [1:0]              func_q;
	logic [CW-1:0]           start_q;
	logic [CW-1:0]           end_q;
	logic [CW-1:0]           ptr_q;
	logic [UW-1:0]           acc_q;
	logic [TWW-1:0]          tw_q;
	logic [CW-1:0]           autos_q;
	logic signed [SW-1:0]    cursor_q;
	logic [EXT_W-1:0]        rem_q;
	logic [PW-1:0]           prod_q;
	logic signed [LEN_W-1:0] need_q;
	logic signed [LEN_W-1:0] mb_q;
	logic signed [LEN_W-1:0] ma_q;

	// Output register.
	logic    out_valid_q;
	result_t out_q;
	result_t out_d;
	logic    out_load;
	logic    out_free;

	// Combinational helpers.
	logic [CW-1:0]           n_c;
	logic [15:0]             n16;
	logic [15:0]             idx16;
	logic [15:0]             s16;
	logic [16:0]             sum17;
	logic [CW-1:0]           cend;
	logic [IW-1:0]           pi;
	logic [1:0]              mode_e;
	logic signed [LEN_W-1:0] val_c;
	logic [EXT_W-1:0]        w_c;
	logic [EXT_W-1:0]        size_c;
	logic [EXT_W-1:0]        pix_c;
	logic                    not_first;
	logic [UW-1:0]           gap_add;
	logic signed [SW-1:0]    excess;
	logic signed [SW-1:0]    rem_c;
	logic [PW-1:0]           div_a;
	logic [TWW-1:0]          div_b;
	logic                    div_busy;
	logic [PW-1:0]           quo;
	logic [EXT_W-1:0]        q_sat;
	logic                    last_step;
	logic                    stepping;
	logic                    load_wr;
	logic [UW-1:0]           res_add;

	// Effective track count.
	always_comb begin
		if (count_q == 6'd0) begin
			n_c = CW'(1);
		end else if ({1'b0, count_q} > 7'(MAX_TRACKS)) begin
			n_c = CW'(MAX_TRACKS);
		end else begin
			n_c = CW'(count_q);
		end
	end

	// Child start and end track, clamped to the grid.
	assign n16   = 16'(n_c);
	assign idx16 = (item.track_index >= n16) ? (n16 - 16'd1) : item.track_index;
	assign s16   = (item.span == 16'd0) ? 16'd1 : item.span;
	assign sum17 = {1'b0, idx16} + {1'b0, s16};
	assign cend  = (sum17 > {1'b0, n16}) ? n_c : CW'(sum17);

	// Current track as seen by the walks.
	assign pi        = ptr_q[IW-1:0];
	assign mode_e    = (count_q == 6'd0) ? MODE_STAR : mode_q[pi];
	assign val_c     = val_q[pi];
	assign w_c       = (count_q == 6'd0 || val_c <= 24'sd0) ? W_ONE : val_c[EXT_W-1:0];
	assign size_c    = size_q[pi];
	assign pix_c     = (val_c > 24'sd0) ? val_c[EXT_W-1:0] : '0;
	assign not_first = ptr_q != start_q;
	assign gap_add   = not_first ? UW'(gap_q) : '0;
	assign last_step = (ptr_q + CW'(1)) == end_q;

	// Space left over after fixed tracks and gaps.
	assign excess = SW'(need_q) - $signed({2'b00, acc_q});
	assign rem_c  = $signed({{(SW-EXT_W){1'b0}}, avail_q}) - $signed({2'b00, acc_q});

	// Contribution of one track to the used space of a resolve.
	always_comb begin
		if (mode_e == MODE_PIXEL) begin
			res_add = UW'(pix_c);
		end else if (mode_e == MODE_STAR) begin
			res_add = '0;
		end else begin
			res_add = UW'(size_c);
		end
	end

	// Shared divider: auto share for need items, star size for resolves.
	assign div_a = (func_q == FUNC_NEED) ? PW'(excess[EXT_W-1:0]) : prod_q;
	assign div_b = (func_q == FUNC_NEED) ? TWW'(autos_q) : tw_q;

	gts_div #(
		.DW(PW),
		.VW(TWW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.quotient (quo)
	);

	assign q_sat = (|quo[PW-1:EXT_W]) ? '1 : quo[EXT_W-1:0];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			gap_q    <= '0;
			avail_q  <= '0;
			origin_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COUNT:  count_q  <= cfg_data[5:0];
				REG_GAP:    gap_q    <= cfg_data[EXT_W-1:0];
				REG_AVAIL:  avail_q  <= cfg_data[EXT_W-1:0];
				REG_ORIGIN: origin_q <= $signed(cfg_data);
				default:    count_q  <= count_q;
			endcase
		end
	end

	assign load_wr = cmd.take && item.func == FUNC_LOAD &&
		item.track_index < 16'(MAX_TRACKS);

	// Mode and value store, written only by load items.
	always_ff @(posedge clk) begin
		if (load_wr) begin
			mode_q[item.track_index[IW-1:0]] <= item.mode;
			val_q[item.track_index[IW-1:0]]  <= item.value;
		end
	end

	// Size and position store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TRACKS; i++) begin
				size_q[i] <= '0;
				pos_q[i]  <= '0;
			end
		end else if (load_wr) begin
			size_q[item.track_index[IW-1:0]] <= '0;
		end else begin
			case (cmd.phase)
				P_NEED_UPD: begin
					if (mode_e == MODE_AUTO && size_c < q_sat) size_q[pi] <= q_sat;
				end
				P_RES_SUM: begin
					if (mode_e == MODE_PIXEL) size_q[pi] <= pix_c;
				end
				P_RES_WR: size_q[pi] <= q_sat;
				P_EMIT:   pos_q[pi]  <= sat_pos(48'(cursor_q));
				default:  size_q[pi] <= size_q[pi];
			endcase
		end
	end

	assign stepping = cmd.phase == P_NEED_SUM || cmd.phase == P_NEED_UPD ||
		cmd.phase == P_RES_SUM || cmd.phase == P_RES_WR || cmd.phase == P_SKIP ||
		cmd.phase == P_EMIT || cmd.phase == P_PLACE_SUM;

	// Walk pointer and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q   <= FUNC_LOAD;
			start_q  <= '0;
			end_q    <= '0;
			ptr_q    <= '0;
			acc_q    <= '0;
			tw_q     <= '0;
			autos_q  <= '0;
			cursor_q <= '0;
			rem_q    <= '0;
			prod_q   <= '0;
			need_q   <= '0;
			mb_q     <= '0;
			ma_q     <= '0;
		end else if (cmd.take) begin
			func_q   <= item.func;
			need_q   <= item.need;
			mb_q     <= item.margin_before;
			ma_q     <= item.margin_after;
			acc_q    <= '0;
			tw_q     <= '0;
			autos_q  <= '0;
			cursor_q <= SW'(origin_q);
			if (item.func == FUNC_RESOLVE) begin
				start_q <= '0;
				end_q   <= n_c;
				ptr_q   <= '0;
			end else begin
				start_q <= CW'(idx16);
				end_q   <= cend;
				ptr_q   <= CW'(idx16);
			end
		end else begin
			if (cmd.rewind) begin
				ptr_q <= start_q;
			end else if (stepping) begin
				ptr_q <= ptr_q + CW'(1);
			end
			case (cmd.phase)
				P_NEED_SUM: begin
					acc_q <= acc_q + gap_add + ((mode_e == MODE_PIXEL) ? UW'(pix_c) : '0);
					if (mode_e == MODE_AUTO) autos_q <= autos_q + CW'(1);
				end
				P_RES_SUM: begin
					acc_q <= acc_q + gap_add + res_add;
					if (mode_e == MODE_STAR) tw_q <= tw_q + TWW'(w_c);
				end
				P_RES_REM:   rem_q    <= (rem_c <= 0) ? '0 : rem_c[EXT_W-1:0];
				P_RES_MUL:   prod_q   <= PW'(rem_q) * PW'(w_c);
				P_EMIT:      cursor_q <= cursor_q + $signed({{(SW-EXT_W){1'b0}}, size_c})
					+ $signed({{(SW-EXT_W){1'b0}}, gap_q});
				P_PLACE_SUM: acc_q    <= acc_q + gap_add + UW'(size_c);
				default:     acc_q    <= acc_q;
			endcase
		end
	end

	// Next result word.
	always_comb begin
		if (cmd.phase == P_EMIT) begin
			out_d.result_index = 5'(ptr_q);
			out_d.position     = sat_pos(48'(cursor_q));
			out_d.extent       = size_c;
			out_d.last         = last_step;
		end else begin
			out_d.result_index = 5'd0;
			out_d.position     = sat_pos(48'(pos_q[start_q[IW-1:0]]) + 48'(mb_q));
			out_d.extent       = sat_ext(48'($signed({1'b0, acc_q})) - 48'(mb_q) - 48'(ma_q));
			out_d.last         = 1'b1;
		end
	end

	assign out_load = cmd.phase == P_EMIT || cmd.phase == P_PLACE_OUT;
	assign out_free = !out_valid_q || !result_stall;

	// Output register holds a word until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= out_d;
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

	assign stat.last_step  = last_step;
	assign stat.autos_nz   = autos_q != '0;
	assign stat.excess_pos = excess > 0;
	assign stat.tw_nz      = tw_q != '0;
	assign stat.is_star    = mode_e == MODE_STAR;
	assign stat.div_busy   = div_busy;
	assign stat.out_free   = out_free;
endmodule

>>> src/grid_track_sizer_core.sv
// Grid track sizer: sizes and places the tracks of one layout grid axis.
// Channels: item (valid/stall) carries load, need, resolve and place words;
// result (valid/stall) returns track or child placement words; cfg
// (valid/ready, always ready) writes the track count, gap, available space and origin.
// With N effective tracks: load finishes at once; need walks the child's span and,
// when it grows tracks, walks it again after a division; resolve walks all N
// tracks to sum, then sizes each star track with one division, the star sizes
// coming from one restoring divider that yields a quotient bit a cycle, and
// walks them once more to emit; place walks the child's span. Track walks visit
// one stored track per cycle while no division or stalled receiver holds them.
// A resolve emits N words, one per cycle while the receiver takes them; the
// last word carries last. A place emits one word; need and load emit none.
// A stalled receiver holds the output register and the track walk waits on it;
// the next item is taken as soon as the last word sits in the output register.
// Reset clears the registers, track sizes and positions; track modes and values
// must be loaded before they are used.
// Depends on gts_pkg, gts_ctrl, gts_dp and gts_div.
module grid_track_sizer_core
	import gts_pkg::*;
#(
	parameter int MAX_TRACKS = GTS_MAX_TRACKS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	cmd_t  cmd;
	stat_t stat;

	// Configuration writes are always accepted and land in the next cycle.
	assign cfg_ready = 1'b1;

	gts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.func       (item.func),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	gts_dp #(
		.MAX_TRACKS(MAX_TRACKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.item         (item),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);
endmodule

>>> tb/grid_track_sizer_core_test.sv
// Self-checking testbench for grid_track_sizer_core: loads tracks, applies child
// needs, resolves and places children, comparing every result word with a predictor.
// Depends on gts_pkg and the grid_track_sizer_core RTL.
`timescale 1ns / 1ps

module grid_track_sizer_core_test;
	import gts_pkg::*;

	localparam int NTRK = 32;
	localparam longint EMAX = 8388607;
	localparam longint PMAX = 8388607;
	localparam longint PMIN = -8388608;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	grid_track_sizer_core u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the grid registers and track store.
	int unsigned sh_count;
	longint      sh_gap;
	longint      sh_avail;
	longint      sh_origin;
	logic [1:0]  sh_mode [NTRK];
	longint      sh_value [NTRK];
	longint      sh_size [NTRK];
	longint      sh_pos [NTRK];
	bit          sh_loaded [NTRK];

	result_t pending_words [$];
	int      fail_count;
	bit      hold_results;
	bit      rand_stall_on;
	int      stall_left;

	// Clock generator.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit.
	initial begin
		#200ms;
		$display("FAIL");
		$finish;
	end

	function automatic longint clamp_ext(longint v);
		return v < 0 ? 0 : (v > EMAX ? EMAX : v);
	endfunction

	function automatic longint clamp_pos(longint v);
		return v < PMIN ? PMIN : (v > PMAX ? PMAX : v);
	endfunction

	function automatic int unsigned tracks_in_use();
		if (sh_count == 0) return 1;
		if (sh_count > NTRK) return NTRK;
		return sh_count;
	endfunction

	function automatic logic [1:0] mode_of(int unsigned i);
		return sh_count == 0 ? MODE_STAR : sh_mode[i];
	endfunction

	function automatic longint weight_of(int unsigned i);
		longint v;
		v = sh_count == 0 ? 0 : sh_value[i];
		return v > 0 ? v : (longint'(1) << FRAC_BITS);
	endfunction

	function automatic void push_word(int unsigned idx, longint p, longint e, bit lst);
		result_t w;
		w.result_index = idx[4:0];
		w.position = p[23:0];
		w.extent = e[22:0];
		w.last = lst;
		pending_words.push_back(w);
	endfunction

	// Predict the results of one item and update the shadow state.
	function automatic void predict_item(item_t it);
		int unsigned n, idx, spn, autos, i;
		longint fixed_len, share, used, total_w, remaining, cursor, span_len, nd;
		n = tracks_in_use();
		if (it.func == FUNC_LOAD) begin
			if (it.track_index < NTRK) begin
				sh_mode[it.track_index] = it.mode;
				sh_value[it.track_index] = longint'(it.value);
				sh_size[it.track_index] = 0;
				sh_loaded[it.track_index] = 1'b1;
			end
			return;
		end
		if (it.func == FUNC_RESOLVE) begin
			used = 0;
			total_w = 0;
			for (i = 0; i < n; i++) begin
				if (mode_of(i) == MODE_PIXEL)
					sh_size[i] = sh_value[i] > 0 ? clamp_ext(sh_value[i]) : 0;
				if (mode_of(i) == MODE_STAR) total_w += weight_of(i);
				else used += sh_size[i];
			end
			remaining = sh_avail - sh_gap * longint'(n - 1) - used;
			if (remaining < 0) remaining = 0;
			if (total_w > 0)
				for (i = 0; i < n; i++)
					if (mode_of(i) == MODE_STAR)
						sh_size[i] = clamp_ext(remaining * weight_of(i) / total_w);
			cursor = sh_origin;
			for (i = 0; i < n; i++) begin
				sh_pos[i] = clamp_pos(cursor);
				cursor += sh_size[i] + sh_gap;
				push_word(i, sh_pos[i], sh_size[i], i + 1 == n);
			end
			return;
		end
		// Child start and span clamped to the tracks in use.
		idx = it.track_index >= n ? n - 1 : it.track_index;
		spn = it.span == 0 ? 1 : it.span;
		if (idx + spn > n) spn = n - idx;
		if (it.func == FUNC_NEED) begin
			autos = 0;
			fixed_len = 0;
			for (i = idx; i < idx + spn; i++) begin
				if (mode_of(i) == MODE_AUTO) autos++;
				else if (mode_of(i) == MODE_PIXEL && sh_value[i] > 0) fixed_len += sh_value[i];
			end
			if (autos == 0) return;
			fixed_len += sh_gap * longint'(spn - 1);
			nd = longint'(it.need);
			if (nd - fixed_len <= 0) return;
			share = clamp_ext((nd - fixed_len) / longint'(autos));
			for (i = idx; i < idx + spn; i++)
				if (mode_of(i) == MODE_AUTO && sh_size[i] < share) sh_size[i] = share;
			return;
		end
		span_len = sh_gap * longint'(spn - 1);
		for (i = idx; i < idx + spn; i++) span_len += sh_size[i];
		push_word(0, clamp_pos(sh_pos[idx] + longint'(it.margin_before)),
			clamp_ext(span_len - (longint'(it.margin_before) + longint'(it.margin_after))),
			1'b1);
	endfunction

	// Result checker: compare each accepted word with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_words.size() == 0) begin
				$error("unexpected result word %p", result);
				fail_count++;
			end else begin
				want = pending_words.pop_front();
				if (result.result_index !== want.result_index) begin
					$error("result_index: expected %0d actual %0d", want.result_index,
						result.result_index);
					fail_count++;
				end
				if (result.position !== want.position) begin
					$error("position: expected %0d actual %0d", want.position, result.position);
					fail_count++;
				end
				if (result.extent !== want.extent) begin
					$error("extent: expected %0d actual %0d", want.extent, result.extent);
					fail_count++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d actual %0d", want.last, result.last);
					fail_count++;
				end
			end
		end
	end

	// Receiver stall pattern with a few long holds; a forced hold overrides it.
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (hold_results) begin
			result_stall <= 1'b1;
		end else if (!rand_stall_on) begin
			result_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (r < 2) begin
			stall_left <= $urandom_range(10, 60);
			result_stall <= 1'b1;
		end else if (r < 30) begin
			result_stall <= ($urandom_range(0, 2) == 0);
		end else begin
			result_stall <= 1'b0;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Send one item word and update the prediction when it is accepted.
	// Valid stays high after acceptance so that words can follow back to back.
	task automatic send_item(item_t it, bit gaps = 1'b1);
		int k;
		k = gaps ? gap_len() : 0;
		if (k > 0) begin
			item_valid <= 1'b0;
			repeat (k) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		predict_item(it);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] ri, logic [23:0] d);
		cfg_index <= ri;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (ri)
			REG_COUNT:  sh_count = d[5:0];
			REG_GAP:    sh_gap = longint'(d[22:0]);
			REG_AVAIL:  sh_avail = longint'(d[22:0]);
			REG_ORIGIN: sh_origin = longint'($signed(d));
			default:    ;
		endcase
	endtask

	task automatic set_grid(int unsigned cnt, int unsigned g, int unsigned av, int org);
		drain();
		write_reg(REG_COUNT, 24'(cnt));
		write_reg(REG_GAP, 24'(g));
		write_reg(REG_AVAIL, 24'(av));
		write_reg(REG_ORIGIN, 24'(org));
		cfg_valid <= 1'b0;
	endtask

	function automatic item_t blank_item(logic [1:0] f);
		item_t it;
		it = '0;
		it.func = f;
		return it;
	endfunction

	function automatic logic signed [23:0] rand_len();
		case ($urandom_range(0, 5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'($urandom_range(0, 255));
			3: return -24'($urandom_range(0, 4096));
			default: return 24'($urandom_range(0, 20000));
		endcase
	endfunction

	task automatic load_track(int unsigned t, logic [1:0] md, logic signed [23:0] v);
		item_t it;
		it = blank_item(FUNC_LOAD);
		it.track_index = 16'(t);
		it.mode = md;
		it.value = v;
		send_item(it);
	endtask

	// Items that touch only loaded tracks (or any track when the count is zero).
	function automatic item_t rand_child(logic [1:0] f);
		item_t it;
		it = blank_item(f);
		it.track_index = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 33));
		it.span = $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 6));
		it.need = rand_len();
		it.margin_before = rand_len();
		it.margin_after = rand_len();
		it.mode = 2'($urandom);
		it.value = 24'($urandom);
		return it;
	endfunction

	task automatic load_all(int unsigned n);
		int unsigned i;
		logic [1:0] md;
		for (i = 0; i < n; i++) begin
			md = 2'($urandom_range(0, 3));
			if (md == 2'd3 && $urandom_range(0, 2) != 0) md = MODE_AUTO;
			load_track(i, md, $urandom_range(0, 2) == 0 ? rand_len() :
				24'($urandom_range(0, 3000)));
		end
	endtask

	// Directed: empty grid, extreme fields, every function and mode.
	task automatic test_directed();
		item_t it;
		set_grid(0, 0, 24'h7FFFFF, 0);
		it = blank_item(FUNC_PLACE);
		send_item(it);
		send_item(blank_item(FUNC_RESOLVE));
		it = blank_item(FUNC_NEED);
		it.need = 24'sh7FFFFF;
		send_item(it);
		it = blank_item(FUNC_PLACE);
		it.track_index = 16'hFFFF;
		it.span = 16'hFFFF;
		it.margin_before = 24'sh800000;
		it.margin_after = 24'sh7FFFFF;
		send_item(it);
		set_grid(4, 16, 4000, -8388608);
		load_track(0, MODE_AUTO, 0);
		load_track(1, MODE_PIXEL, 24'sh7FFFFF);
		load_track(2, MODE_STAR, 24'sh800000);
		load_track(3, 2'd3, 512);
		load_track(16'hFFFF, MODE_PIXEL, 5);
		it = blank_item(FUNC_NEED);
		it.span = 0;
		it.need = 24'sh7FFFFF;
		send_item(it);
		it.span = 4;
		it.need = 24'sh800000;
		send_item(it);
		send_item(blank_item(FUNC_RESOLVE));
		it = blank_item(FUNC_PLACE);
		it.track_index = 1;
		it.span = 3;
		it.margin_before = 24'sh7FFFFF;
		send_item(it);
		set_grid(40, 24'h7FFFFF, 0, 24'h7FFFFF);
		load_all(NTRK);
		send_item(blank_item(FUNC_RESOLVE));
		send_item(rand_child(FUNC_PLACE));
	endtask

	// Random phases over several grid settings.
	task automatic test_random(int unsigned items);
		int unsigned sent, cnt, k;
		item_t it;
		sent = 0;
		while (sent < items) begin
			cnt = $urandom_range(0, 5) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 8);
			set_grid(cnt, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64),
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 60000),
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000));
			load_all(cnt > NTRK ? NTRK : cnt);
			sent += cnt > NTRK ? NTRK : cnt;
			for (k = 0; k < 30; k++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: it = rand_child(FUNC_NEED);
					4, 5: it = blank_item(FUNC_RESOLVE);
					6, 7, 8: it = rand_child(FUNC_PLACE);
					default: begin
						it = rand_child(FUNC_LOAD);
						if (it.track_index < NTRK && !sh_loaded[it.track_index])
							it.track_index = 16'($urandom_range(NTRK, 65535));
					end
				endcase
				if (it.func == FUNC_RESOLVE) it.value = 24'($urandom);
				send_item(it);
				sent++;
			end
		end
	endtask

	// Backpressure: hold the receiver while items keep coming, then a receiver that never stalls.
	task automatic test_backpressure();
		int k;
		set_grid(32, 8, 100000, 0);
		load_all(NTRK);
		fork
			begin
				hold_results = 1'b1;
				repeat (400) @(posedge clk);
				hold_results = 1'b0;
			end
			for (k = 0; k < 6; k++) send_item(k % 2 ? rand_child(FUNC_PLACE) :
				blank_item(FUNC_RESOLVE), 1'b0);
		join
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0);
		rand_stall_on = 1'b0;
		for (k = 0; k < 6; k++) send_item(blank_item(FUNC_RESOLVE), 1'b0);
		rand_stall_on = 1'b1;
	endtask

	initial begin
		int unsigned i;
		fail_count = 0;
		hold_results = 1'b0;
		rand_stall_on = 1'b1;
		stall_left = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_COUNT;
		cfg_data = '0;
		sh_count = 0; sh_gap = 0; sh_avail = 0; sh_origin = 0;
		for (i = 0; i < NTRK; i++) begin
			sh_mode[i] = MODE_AUTO; sh_value[i] = 0; sh_size[i] = 0; sh_pos[i] = 0;
			sh_loaded[i] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(500);
		test_backpressure();
		drain();
		if (fail_count == 0 && pending_words.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
